### hdl/htfd_pkg.sv
// ----------------------------------------------------------------------------
// htfd_pkg
// Shared types, constants and the CRC-8 byte step for the frame decoder.
// ----------------------------------------------------------------------------
package htfd_pkg;

    typedef logic [15:0]        raw_word_t;
    typedef logic signed [14:0] temp_centi_t;
    typedef logic [13:0]        hum_centi_t;

    // Converted values for one frame
    typedef struct packed {
        temp_centi_t temp_centi;
        hum_centi_t  hum_centi;
    } scaled_t;

    localparam logic [7:0]         CRC_INIT    = 8'hFF;
    localparam logic [7:0]         CRC_POLY    = 8'h31;

    // Full-scale spans in hundredths and the temperature offset
    localparam logic [14:0]        TEMP_SPAN   = 15'd17500;
    localparam logic [13:0]        HUM_SPAN    = 14'd10000;
    localparam logic signed [15:0] TEMP_OFFSET = 16'sd4500;
    localparam logic [16:0]        FULL_SCALE  = 17'd65535;

    // One byte through CRC-8, MSB first, no final XOR
    function automatic logic [7:0] crc8_byte(input logic [7:0] crc_in,
                                             input logic [7:0] data);
        logic [7:0] c;
        c = crc_in ^ data;
        for (int i = 0; i < 8; i++) begin
            c = c[7] ? ({c[6:0], 1'b0} ^ CRC_POLY) : {c[6:0], 1'b0};
        end
        return c;
    endfunction

endpackage

### hdl/htfd_scale.sv
// ----------------------------------------------------------------------------
// htfd_scale
// Scale raw sensor words to hundredths of degC and of %RH.
// ----------------------------------------------------------------------------
module htfd_scale (
    input  htfd_pkg::raw_word_t raw_temperature,
    input  htfd_pkg::raw_word_t raw_humidity,
    output htfd_pkg::scaled_t   scaled
);
    import htfd_pkg::*;

    // floor(x / 65535) for x < 2^31: x = q0*65536 + lo, so the remainder
    // against 65535 is lo + q0, which stays below twice the divisor.
    function automatic logic [15:0] div_full_scale(input logic [30:0] x);
        logic [14:0] q0;
        logic [16:0] rem;
        q0  = x[30:16];
        rem = {1'b0, x[15:0]} + {2'b00, q0};
        return {1'b0, q0} + 16'((rem >= FULL_SCALE) ? 1 : 0);
    endfunction

    logic [30:0]        temp_prod;
    logic [30:0]        hum_prod;
    logic [15:0]        temp_quot;
    logic [15:0]        hum_quot;
    logic signed [15:0] temp_shifted;

    assign temp_prod    = 31'(raw_temperature) * 31'(TEMP_SPAN);
    assign hum_prod     = 31'(raw_humidity) * 31'(HUM_SPAN);
    assign temp_quot    = div_full_scale(temp_prod);
    assign hum_quot     = div_full_scale(hum_prod);
    assign temp_shifted = $signed(temp_quot) - TEMP_OFFSET;

    assign scaled.temp_centi = temp_shifted[14:0];
    assign scaled.hum_centi  = hum_quot[13:0];

endmodule

### hdl/humidity_temp_frame_decoder.sv
// ----------------------------------------------------------------------------
// humidity_temp_frame_decoder
// Decode a six-byte temperature/humidity sensor frame with CRC-8 checks.
// ----------------------------------------------------------------------------
// Usage:
//   Feed the sensor read-back one byte per word on the s_ channel: temperature
//   MSB, LSB, CRC, humidity MSB, LSB, CRC. Set s_tuser on a word to mark the
//   first byte of a frame; this drops any partial frame. After six bytes the
//   position wraps and the next byte starts a new frame anyway.
//   Each sixth byte yields one word on the m_ channel: converted values (last
//   good ones on a CRC error), the raw words of this frame and a status flag
//   in m_tuser (0 good and updated, 1 CRC mismatch).
// Throughput and pipeline:
//   One byte per cycle, sustained while the output register has room. A byte
//   is registered in the input register and decoded at its exit; the result
//   word is registered in the output register. The per-byte CRC step and
//   the constant multiply and divide-by-65535 of the scaler set the cycle.
// Reset and stalls:
//   aresetn clears the byte position and last good values (both read 0 until
//   a good frame arrives) and presets the CRC. While m_tready is low a result
//   word holds in the output register; bytes one to five still advance, and
//   the sixth byte waits in the input register, so s_tready drops only then.
// ----------------------------------------------------------------------------
module humidity_temp_frame_decoder (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [7:0] rx_byte
    input  logic        s_tuser,   // [0] frame_start
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [63:0] m_tdata,   // [14:0] temperature_centi, [28:15] humidity_centi,
                                   // [44:29] raw_temperature, [60:45] raw_humidity,
                                   // [63:61] zero
    output logic        m_tuser    // [0] status
);
    import htfd_pkg::*;

    localparam logic [2:0] POS_TEMP_MSB = 3'd0;
    localparam logic [2:0] POS_TEMP_LSB = 3'd1;
    localparam logic [2:0] POS_TEMP_CRC = 3'd2;
    localparam logic [2:0] POS_HUM_MSB  = 3'd3;
    localparam logic [2:0] POS_HUM_LSB  = 3'd4;
    localparam logic [2:0] POS_HUM_CRC  = 3'd5;

    // Input register
    logic        in_valid_reg, in_valid_next;
    logic [7:0]  in_byte_reg,  in_byte_next;
    logic        in_start_reg, in_start_next;

    // Frame state
    logic [2:0]  pos_reg,       pos_next;
    logic [7:0]  crc_reg,       crc_next;
    logic [7:0]  high_reg,      high_next;
    raw_word_t   temp_word_reg, temp_word_next;
    raw_word_t   hum_word_reg,  hum_word_next;
    logic        temp_good_reg, temp_good_next;
    temp_centi_t last_temp_reg, last_temp_next;
    hum_centi_t  last_hum_reg,  last_hum_next;

    // Output register
    logic        out_valid_reg, out_valid_next;
    logic [63:0] out_data_reg,  out_data_next;
    logic        out_user_reg,  out_user_next;

    logic        advance;
    logic        frame_end;
    logic        frame_good;
    logic [2:0]  pos;
    logic [7:0]  crc_step;
    scaled_t     scaled;

    htfd_scale u_scale (
        .raw_temperature (temp_word_reg),
        .raw_humidity    (hum_word_reg),
        .scaled          (scaled)
    );

    // Position of the byte in the input register; frame start restarts it
    always_comb begin
        if (in_start_reg || pos_reg > POS_HUM_CRC) begin
            pos = POS_TEMP_MSB;
        end else begin
            pos = pos_reg;
        end
    end

    assign frame_end  = (pos == POS_HUM_CRC);
    // Only the frame's last byte needs room in the output register
    assign advance    = in_valid_reg && (!frame_end || !out_valid_reg || m_tready);
    assign s_tready   = !in_valid_reg || advance;
    assign crc_step   = crc8_byte((pos == POS_TEMP_MSB || pos == POS_HUM_MSB)
                                  ? CRC_INIT : crc_reg, in_byte_reg);
    assign frame_good = temp_good_reg && (crc_reg == in_byte_reg);

    always_comb begin
        // Input register: load on accept, empty once decoded
        in_valid_next = in_valid_reg;
        in_byte_next  = in_byte_reg;
        in_start_next = in_start_reg;
        if (s_tvalid && s_tready) begin
            in_valid_next = 1'b1;
            in_byte_next  = s_tdata;
            in_start_next = s_tuser;
        end else if (advance) begin
            in_valid_next = 1'b0;
        end

        pos_next       = pos_reg;
        crc_next       = crc_reg;
        high_next      = high_reg;
        temp_word_next = temp_word_reg;
        hum_word_next  = hum_word_reg;
        temp_good_next = temp_good_reg;
        last_temp_next = last_temp_reg;
        last_hum_next  = last_hum_reg;

        if (advance) begin
            pos_next = frame_end ? POS_TEMP_MSB : pos + 3'd1;
            unique case (pos)
                POS_TEMP_MSB, POS_HUM_MSB: begin
                    crc_next  = crc_step;
                    high_next = in_byte_reg;
                end
                POS_TEMP_LSB: begin
                    crc_next       = crc_step;
                    temp_word_next = {high_reg, in_byte_reg};
                end
                POS_HUM_LSB: begin
                    crc_next      = crc_step;
                    hum_word_next = {high_reg, in_byte_reg};
                end
                POS_TEMP_CRC: begin
                    temp_good_next = (crc_reg == in_byte_reg);
                end
                default: begin
                    // humidity CRC: checked below
                end
            endcase
            if (frame_end && frame_good) begin
                last_temp_next = scaled.temp_centi;
                last_hum_next  = scaled.hum_centi;
            end
        end

        // Output register: hold until taken
        out_valid_next = out_valid_reg;
        out_data_next  = out_data_reg;
        out_user_next  = out_user_reg;
        if (advance && frame_end) begin
            out_valid_next = 1'b1;
            out_data_next  = {3'b000, hum_word_reg, temp_word_reg,
                              last_hum_next, last_temp_next};
            out_user_next  = !frame_good;
        end else if (m_tready) begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            pos_reg       <= POS_TEMP_MSB;
            crc_reg       <= CRC_INIT;
            high_reg      <= '0;
            temp_word_reg <= '0;
            hum_word_reg  <= '0;
            temp_good_reg <= 1'b0;
            last_temp_reg <= '0;
            last_hum_reg  <= '0;
        end else begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
            pos_reg       <= pos_next;
            crc_reg       <= crc_next;
            high_reg      <= high_next;
            temp_word_reg <= temp_word_next;
            hum_word_reg  <= hum_word_next;
            temp_good_reg <= temp_good_next;
            last_temp_reg <= last_temp_next;
            last_hum_reg  <= last_hum_next;
        end
        in_byte_reg  <= in_byte_next;
        in_start_reg <= in_start_next;
        out_data_reg <= out_data_next;
        out_user_reg <= out_user_next;
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;
    assign m_tuser  = out_user_reg;

endmodule
